[rtl/swm_pkg.sv]
// Package for the sliding window maximum block.
// Holds default sizes, the configuration register width and the cell control struct.
// No dependencies; used by swm_cell and sliding_window_max.
package swm_pkg;

   localparam int WINDOW_MAX_DEF   = 64;
   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int CSR_WIDTH        = 7;

   // Per-cycle command broadcast to every cell of the deque.
   typedef struct packed {
      logic step;     // append the held sample and prune the tail
      logic shift;    // move every cell one place toward the head
      logic restart;  // treat all stored cells as empty
   } cell_ctrl_type;

endpackage

[rtl/swm_cell.sv]
// One deque cell: a stored candidate value, its age and a valid bit.
// Depends on swm_pkg for the control struct; instantiated in a row by sliding_window_max.
module swm_cell #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int AGE_W        = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  swm_pkg::cell_ctrl_type      ctrl,
   input  logic [SAMPLE_WIDTH-1:0]     sample,
   input  logic [AGE_W-1:0]            age_limit,
   input  logic                        left_keep,
   input  logic [SAMPLE_WIDTH-1:0]     nb_value,
   input  logic [AGE_W-1:0]            nb_age,
   input  logic                        nb_valid,
   output logic [SAMPLE_WIDTH-1:0]     value,
   output logic [AGE_W-1:0]            age,
   output logic                        valid,
   output logic                        keep,
   output logic                        drop
);
   import swm_pkg::*;

   logic [SAMPLE_WIDTH-1:0] value_ff, value_in;
   logic [AGE_W-1:0]        age_ff, age_in;
   logic                    valid_ff, valid_in;
   logic [SAMPLE_WIDTH-1:0] src_value;
   logic [AGE_W-1:0]        src_age;
   logic                    src_valid;

   // Source seen by this cell: its own contents, or its neighbor's when the head leaves.
   assign src_value = ctrl.shift ? nb_value : value_ff;
   assign src_age   = ctrl.shift ? nb_age : age_ff;
   assign src_valid = (ctrl.shift ? nb_valid : valid_ff) && !ctrl.restart;

   assign keep = src_valid && ($signed(src_value) > $signed(sample));
   assign drop = valid_ff && !ctrl.restart && (age_ff >= age_limit);

   always_comb begin
      value_in = value_ff;
      age_in   = age_ff;
      valid_in = valid_ff;
      if (ctrl.step) begin
         if (keep) begin
            value_in = src_value;
            age_in   = src_age + 1'b1;
            valid_in = 1'b1;
         end else if (left_keep) begin
            // first free place behind the surviving candidates
            value_in = sample;
            age_in   = '0;
            valid_in = 1'b1;
         end else begin
            valid_in = 1'b0;
         end
      end else if (ctrl.shift) begin
         value_in = nb_value;
         age_in   = nb_age;
         valid_in = nb_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      age_ff   <= age_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign age   = age_ff;
   assign valid = valid_ff;

endmodule

[rtl/sliding_window_max.sv]
// Sliding window maximum over signed samples, kept as a monotonic deque in a row of cells.
// An accepted sample is registered in the hold stage; its result is then registered at rsp.
// Throughput: one sample per cycle while rsp is not stalled; each extra head cell that has
// aged out after the window was shortened holds the sample back while the row shifts toward the head.
// Reset clears the valid bits and the fill count and sets window_len to 1; no clearing pass.
module sliding_window_max #(
   parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
   localparam int DATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [swm_pkg::CSR_WIDTH-1:0]   csr_data,    // window_len
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [DATA_W-1:0]               req_tdata,   // sample
   input  logic [0:0]                      req_tuser,   // restart
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [DATA_W-1:0]               rsp_tdata    // window_max
);
   import swm_pkg::*;

   localparam int LEN_W = $clog2(WINDOW_MAX + 1);

   logic [CSR_WIDTH-1:0]    window_len_ff, window_len_in;
   logic                    hold_valid_ff, hold_valid_in;
   logic [SAMPLE_WIDTH-1:0] hold_sample_ff, hold_sample_in;
   logic                    hold_restart_ff, hold_restart_in;
   logic [LEN_W-1:0]        fill_count_ff, fill_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_value_ff, rsp_value_in;

   logic [LEN_W-1:0]        w_eff;
   logic [LEN_W-1:0]        age_limit;
   logic [LEN_W-1:0]        fill_base;
   logic [LEN_W-1:0]        fill_next;
   logic                    out_free;
   logic                    multi_drop;
   logic                    hold_done;
   logic [SAMPLE_WIDTH-1:0] head_next;
   cell_ctrl_type           ctrl;

   logic [SAMPLE_WIDTH-1:0] cell_value [WINDOW_MAX];
   logic [LEN_W-1:0]        cell_age   [WINDOW_MAX];
   logic [SAMPLE_WIDTH-1:0] nb_value   [WINDOW_MAX];
   logic [LEN_W-1:0]        nb_age     [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]   nb_valid;
   logic [WINDOW_MAX-1:0]   cell_valid;
   logic [WINDOW_MAX-1:0]   keep;
   logic [WINDOW_MAX-1:0]   drop;
   logic [WINDOW_MAX-1:0]   left_keep;

   // Configuration
   assign csr_ready     = 1'b1;
   assign window_len_in = (csr_valid && csr_ready) ? csr_data : window_len_ff;

   always_comb begin
      if (window_len_ff == '0) begin
         w_eff = LEN_W'(1);
      end else if (int'(window_len_ff) > WINDOW_MAX) begin
         w_eff = LEN_W'(WINDOW_MAX);
      end else begin
         w_eff = LEN_W'(window_len_ff);
      end
   end
   assign age_limit = w_eff - 1'b1;

   // Control: hold one sample until the row can take it in a single step
   generate
      if (WINDOW_MAX > 1) begin : g_multi
         assign multi_drop = drop[0] && drop[1];
      end else begin : g_single
         assign multi_drop = 1'b0;
      end
   endgenerate

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign hold_done = hold_valid_ff && !multi_drop && out_free;
   assign req_tready = !hold_valid_ff || hold_done;

   assign ctrl.step    = hold_done;
   assign ctrl.shift   = hold_valid_ff && drop[0] && (multi_drop || out_free);
   assign ctrl.restart = hold_restart_ff;

   always_comb begin
      hold_valid_in   = hold_valid_ff;
      hold_sample_in  = hold_sample_ff;
      hold_restart_in = hold_restart_ff;
      if (req_tvalid && req_tready) begin
         hold_valid_in   = 1'b1;
         hold_sample_in  = req_tdata[SAMPLE_WIDTH-1:0];
         hold_restart_in = req_tuser[0];
      end else if (hold_done) begin
         hold_valid_in = 1'b0;
      end
   end

   assign fill_base = hold_restart_ff ? '0 : fill_count_ff;
   assign fill_next = (fill_base < LEN_W'(WINDOW_MAX)) ? fill_base + 1'b1 : fill_base;
   assign fill_count_in = hold_done ? fill_next : fill_count_ff;

   // New head value after this step
   assign head_next = keep[0] ? (ctrl.shift ? nb_value[0] : cell_value[0]) : hold_sample_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (hold_done) begin
         rsp_valid_in = (fill_next >= w_eff);
         rsp_value_in = head_next;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      hold_sample_ff  <= hold_sample_in;
      hold_restart_ff <= hold_restart_in;
      rsp_value_ff    <= rsp_value_in;
      if (reset) begin
         window_len_ff <= CSR_WIDTH'(1);
         hold_valid_ff <= 1'b0;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         window_len_ff <= window_len_in;
         hold_valid_ff <= hold_valid_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_value_ff);

   // Row of cells, head at index 0
   generate
      for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
         if (i == WINDOW_MAX - 1) begin : g_last
            assign nb_value[i] = '0;
            assign nb_age[i]   = '0;
            assign nb_valid[i] = 1'b0;
         end else begin : g_inner
            assign nb_value[i] = cell_value[i+1];
            assign nb_age[i]   = cell_age[i+1];
            assign nb_valid[i] = cell_valid[i+1];
         end
         if (i == 0) begin : g_head
            assign left_keep[i] = 1'b1;
         end else begin : g_body
            assign left_keep[i] = keep[i-1];
         end

         swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_W        (LEN_W)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .sample    (hold_sample_ff),
            .age_limit (age_limit),
            .left_keep (left_keep[i]),
            .nb_value  (nb_value[i]),
            .nb_age    (nb_age[i]),
            .nb_valid  (nb_valid[i]),
            .value     (cell_value[i]),
            .age       (cell_age[i]),
            .valid     (cell_valid[i]),
            .keep      (keep[i]),
            .drop      (drop[i])
         );
      end
   endgenerate

   // Valid cells always form a prefix from the head.
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (((cell_valid + 1'b1) & cell_valid) == '0))
      else $error("deque valid bits are not a prefix");

   // A completed step always leaves the new sample in the row, so the head is valid.
   a_head_after_step: assert property (@(posedge clock) disable iff (reset)
      hold_done |=> cell_valid[0])
      else $error("head cell empty after step");

   // An accepted transfer is held for processing.
   a_accept_held: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> hold_valid_ff)
      else $error("accepted sample not held");

endmodule

[bench/swm_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for sliding_window_max: watches the csr, req and rsp channels.
// Keeps its own deque of candidate maxima and compares every rsp transfer with it.
// Depends on swm_pkg for the register width and the default deque depth.
module swm_checker #(
   parameter int DEPTH = swm_pkg::WINDOW_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [swm_pkg::CSR_WIDTH-1:0] csr_data,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [31:0]                   req_tdata,    // sample
   input  logic [0:0]                    req_tuser,    // restart
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [31:0]                   rsp_tdata,    // window_max
   output int                            fail_count,
   output int                            pending,
   output int                            checked
);
   import swm_pkg::*;

   logic signed [31:0]   cand_value [DEPTH];
   int                   cand_age [DEPTH];
   int                   cand_count;
   int                   seen_count;
   logic [CSR_WIDTH-1:0] span_reg;
   logic signed [31:0]   max_queue [$];

   // Advance the candidate deque by one sample and queue the window maximum if one is due.
   task automatic admit_sample(input logic signed [31:0] s, input logic fresh);
      int span;
      span = (span_reg == 0) ? 1 : (span_reg > DEPTH) ? DEPTH : int'(span_reg);
      if (fresh) begin
         cand_count = 0;
         seen_count = 0;
      end
      for (int i = 0; i < cand_count; i++)
         cand_age[i]++;
      // drop head entries that have left the window
      while (cand_count > 0 && cand_age[0] >= span) begin
         for (int i = 1; i < cand_count; i++) begin
            cand_value[i-1] = cand_value[i];
            cand_age[i-1]   = cand_age[i];
         end
         cand_count--;
      end
      // pop tail entries not above the new sample, so the newest of equals stays
      while (cand_count > 0 && cand_value[cand_count-1] <= s)
         cand_count--;
      if (cand_count < DEPTH) begin
         cand_value[cand_count] = s;
         cand_age[cand_count]   = 0;
         cand_count++;
      end
      if (seen_count < DEPTH)
         seen_count++;
      if (seen_count >= span && cand_count > 0)
         max_queue.insert(max_queue.size(), cand_value[0]);
   endtask

   always @(posedge clock) begin
      logic signed [31:0] want;
      if (reset) begin
         cand_count = 0;
         seen_count = 0;
         span_reg   = 1;
         max_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (max_queue.size() == 0) begin
               fail_count++;
               $error("window_max: no result expected, got %0d", $signed(rsp_tdata));
            end else begin
               want = max_queue[0];
               max_queue.delete(0);
               checked++;
               if (rsp_tdata !== want) begin
                  fail_count++;
                  $error("window_max: expected %0d, got %0d", want, $signed(rsp_tdata));
               end
            end
         end
         if (csr_valid && csr_ready)
            span_reg = csr_data;
         if (req_tvalid && req_tready)
            admit_sample($signed(req_tdata), req_tuser[0]);
      end
      pending = max_queue.size();
   end

endmodule

[bench/tb_sliding_window_max.sv]
`timescale 1ns / 100ps
// Top of the sliding_window_max bench: clock, reset, sample stimulus and the verdict.
// Depends on swm_pkg, the sliding_window_max RTL and swm_checker.
module tb_sliding_window_max;
   import swm_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 80;
   localparam int RANDOM_ITEMS  = 500;
   localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKE} rx_mode_type;
   typedef enum {SHAPE_WIDE, SHAPE_NARROW, SHAPE_FALLING, SHAPE_RISING, SHAPE_EDGES} shape_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_WIDTH-1:0] csr_data   = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;   // sample
   logic [0:0]           req_tuser  = '0;   // restart
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [31:0]          rsp_tdata;         // window_max

   int fail_count;
   int pending;
   int checked;
   int sent        = 0;
   int windows_set = 0;
   int burst_left  = 0;
   int quiet_cycles = 0;

   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;
   int          rx_tick = 0;

   always #10 clock = ~clock;

   sliding_window_max dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   swm_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   // Receiver back-pressure: switch at random between four stall patterns.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(32, 200);
      end else begin
         rx_left--;
      end
      rx_tick++;
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= (rx_tick % 5 == 0);
         RX_CHOKE:  rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("tb_sliding_window_max: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one sample; senders work in bursts with random gaps in between.
   task automatic push_sample(input logic signed [31:0] s, input logic fresh);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tuser  <= fresh;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // Write window_len once the block has drained and finished any head shifting.
   task automatic set_window(input logic [CSR_WIDTH-1:0] span);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= span;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      windows_set++;
   endtask

   initial begin
      logic [CSR_WIDTH-1:0] span;
      logic signed [31:0]   s;
      logic signed [31:0]   level;
      shape_type            shape;
      logic                 fresh;
      int                   eff;
      int                   run_len;
      int                   target;
      int                   phase;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset window of one: every sample is its own maximum
      push_sample(32'sd17, 1'b0);
      push_sample(S_MIN, 1'b0);

      // warm-up, extremes and runs of equal values
      set_window(CSR_WIDTH'(3));
      push_sample(S_MIN, 1'b1);
      push_sample(S_MAX, 1'b0);
      push_sample(-32'sd1, 1'b0);
      push_sample(32'sd0, 1'b0);
      push_sample(32'sd0, 1'b0);
      push_sample(-32'sd1, 1'b0);
      push_sample(S_MIN, 1'b0);
      push_sample(S_MIN, 1'b0);
      push_sample(S_MIN, 1'b0);

      // fill a falling deque, then shrink the window under it
      set_window(CSR_WIDTH'(5));
      push_sample(32'sd10, 1'b1);
      push_sample(32'sd9, 1'b0);
      push_sample(32'sd8, 1'b0);
      push_sample(32'sd7, 1'b0);
      push_sample(32'sd6, 1'b0);
      set_window(CSR_WIDTH'(2));
      push_sample(32'sd1, 1'b0);
      push_sample(32'sd0, 1'b0);

      // grow it again: dropped candidates stay lost
      set_window(CSR_WIDTH'(5));
      push_sample(-32'sd1, 1'b0);
      push_sample(-32'sd2, 1'b0);

      // zero acts as one, oversized acts as the deque depth
      set_window(CSR_WIDTH'(0));
      push_sample(32'sd4, 1'b0);
      push_sample(S_MAX, 1'b0);
      set_window(CSR_WIDTH'(127));
      push_sample(32'sd1, 1'b1);

      target = sent + RANDOM_ITEMS;
      phase  = 0;
      while (sent < target) begin
         case (phase)
            0:       span = CSR_WIDTH'(64);
            1:       span = CSR_WIDTH'(127);
            2:       span = CSR_WIDTH'(1);
            3:       span = CSR_WIDTH'(0);
            default: begin
               case ($urandom_range(0, 7))
                  0:       span = CSR_WIDTH'(0);
                  1:       span = CSR_WIDTH'(1);
                  2:       span = CSR_WIDTH'(64);
                  3:       span = CSR_WIDTH'($urandom_range(65, 127));
                  4:       span = CSR_WIDTH'($urandom_range(2, 4));
                  default: span = CSR_WIDTH'($urandom_range(1, 64));
               endcase
            end
         endcase
         set_window(span);
         eff     = (span == 0) ? 1 : (span > 64) ? 64 : int'(span);
         run_len = eff + $urandom_range(4, 40);
         shape   = shape_type'($urandom_range(0, 4));
         // most runs restart; the rest carry the old deque into the new window
         fresh   = ($urandom_range(0, 3) != 0);
         level   = (shape == SHAPE_FALLING) ? S_MAX - $urandom_range(0, 1000)
                                            : S_MIN + $urandom_range(0, 1000);
         for (int k = 0; k < run_len && sent < target; k++) begin
            case (shape)
               SHAPE_WIDE:    s = $urandom();
               SHAPE_NARROW:  s = $urandom_range(0, 8) - 4;
               SHAPE_FALLING: begin
                  level = level - $urandom_range(0, 3);
                  s     = level;
               end
               SHAPE_RISING:  begin
                  level = level + $urandom_range(0, 3);
                  s     = level;
               end
               SHAPE_EDGES:   begin
                  case ($urandom_range(0, 3))
                     0:       s = S_MIN;
                     1:       s = S_MAX;
                     2:       s = 32'sd0;
                     default: s = -32'sd1;
                  endcase
               end
            endcase
            // occasional noise sample breaks a shaped run
            if ($urandom_range(0, 19) == 0)
               s = $urandom();
            push_sample(s, (k == 0 && fresh) || ($urandom_range(0, 59) == 0));
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Ran %0d samples across %0d window settings (0, 1, 64 and oversized included);",
               sent, windows_set);
      $display("compared %0d window maxima, %0d mismatches.", checked, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_sliding_window_max: PASS");
      end else begin
         $display("tb_sliding_window_max: FAIL");
      end
      $finish;
   end

endmodule
